// File: rtl/md5s_pkg.sv
// md5 hasher package: microcode words, round tables and helper functions
package md5s_pkg;

    localparam int unsigned BUF_WORDS = 16;
    localparam int unsigned BUF_AW    = 4;

    localparam logic [3:0] LEN_LO_ADDR = 4'd14;
    localparam logic [3:0] LEN_HI_ADDR = 4'd15;

    localparam logic [31:0] IV [4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };

    // microcode step addresses
    typedef logic [3:0] t_pc;
    localparam t_pc S_IDLE  = 4'd0;
    localparam t_pc S_PADH  = 4'd1;
    localparam t_pc S_ZLO   = 4'd2;
    localparam t_pc S_ZHI   = 4'd3;
    localparam t_pc S_LENL  = 4'd4;
    localparam t_pc S_LENH  = 4'd5;
    localparam t_pc S_CINIT = 4'd6;
    localparam t_pc S_CRND  = 4'd7;
    localparam t_pc S_CFIN  = 4'd8;
    localparam t_pc S_EMIT  = 4'd9;

    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_PADHEAD,
        OP_ZLO,
        OP_ZHI,
        OP_LENLO,
        OP_LENHI,
        OP_CINIT,
        OP_ROUND,
        OP_CFIN,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_BLKDONE,
        C_LASTACC,
        C_HIGHPAD,
        C_WPTR14,
        C_WPTR16,
        C_RNDLAST,
        C_RETURN,
        C_OUTBUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond_a;
        t_pc   tgt_a;
        t_cond cond_b;
        t_pc   tgt_b;
        t_pc   nxt;
        logic  set_ret;
        t_pc   ret;
    } t_ctrl;

    typedef struct packed {
        logic blkdone;
        logic lastacc;
        logic highpad;
        logic wptr14;
        logic wptr16;
        logic rndlast;
        logic outbusy;
    } t_flags;

    function automatic t_ctrl ucode(t_pc pc);
        t_ctrl w;
        w = '{op: OP_ACCEPT, cond_a: C_NEVER, tgt_a: S_IDLE, cond_b: C_NEVER,
              tgt_b: S_IDLE, nxt: S_IDLE, set_ret: 1'b0, ret: S_IDLE};
        unique case (pc)
            S_IDLE: begin
                w.op = OP_ACCEPT;
                w.cond_a = C_BLKDONE; w.tgt_a = S_CINIT;
                w.cond_b = C_LASTACC; w.tgt_b = S_PADH;
                w.nxt = S_IDLE;
            end
            S_PADH: begin
                w.op = OP_PADHEAD;
                w.cond_a = C_HIGHPAD; w.tgt_a = S_ZHI;
                w.nxt = S_ZLO;
            end
            S_ZLO: begin
                w.op = OP_ZLO;
                w.cond_a = C_WPTR14; w.tgt_a = S_LENL;
                w.nxt = S_ZLO;
            end
            S_ZHI: begin
                w.op = OP_ZHI;
                w.cond_a = C_WPTR16; w.tgt_a = S_CINIT;
                w.set_ret = 1'b1; w.ret = S_ZLO;
                w.nxt = S_ZHI;
            end
            S_LENL: begin
                w.op = OP_LENLO;
                w.nxt = S_LENH;
            end
            S_LENH: begin
                w.op = OP_LENHI;
                w.cond_a = C_ALWAYS; w.tgt_a = S_CINIT;
                w.set_ret = 1'b1; w.ret = S_EMIT;
            end
            S_CINIT: begin
                w.op = OP_CINIT;
                w.nxt = S_CRND;
            end
            S_CRND: begin
                w.op = OP_ROUND;
                w.cond_a = C_RNDLAST; w.tgt_a = S_CFIN;
                w.nxt = S_CRND;
            end
            S_CFIN: begin
                w.op = OP_CFIN;
                w.cond_a = C_RETURN;
            end
            S_EMIT: begin
                w.op = OP_EMIT;
                w.cond_a = C_OUTBUSY; w.tgt_a = S_EMIT;
                w.nxt = S_IDLE;
            end
            default: begin
                w.op = OP_ACCEPT;
                w.nxt = S_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic eval_cond(t_cond c, t_flags f);
        logic r;
        unique case (c)
            C_NEVER:   r = 1'b0;
            C_ALWAYS:  r = 1'b1;
            C_BLKDONE: r = f.blkdone;
            C_LASTACC: r = f.lastacc;
            C_HIGHPAD: r = f.highpad;
            C_WPTR14:  r = f.wptr14;
            C_WPTR16:  r = f.wptr16;
            C_RNDLAST: r = f.rndlast;
            C_RETURN:  r = 1'b1;
            C_OUTBUSY: r = f.outbusy;
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

    // message word used by round i
    function automatic logic [3:0] msg_index(logic [5:0] i);
        logic [3:0] lo;
        logic [3:0] k;
        lo = i[3:0];
        unique case (i[5:4])
            2'd0:    k = lo;
            2'd1:    k = lo * 4'd5 + 4'd1;
            2'd2:    k = lo * 4'd3 + 4'd5;
            default: k = lo * 4'd7;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0:    s = 5'd7;
            4'd1:    s = 5'd12;
            4'd2:    s = 5'd17;
            4'd3:    s = 5'd22;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd9;
            4'd6:    s = 5'd14;
            4'd7:    s = 5'd20;
            4'd8:    s = 5'd4;
            4'd9:    s = 5'd11;
            4'd10:   s = 5'd16;
            4'd11:   s = 5'd23;
            4'd12:   s = 5'd6;
            4'd13:   s = 5'd10;
            4'd14:   s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

endpackage

// File: rtl/md5s_ram.sv
// generic simple dual-port ram with registered read
module md5s_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/md5s_round.sv
// one md5 round step: mixing function, constant add and rotate
module md5s_round import md5s_pkg::*; (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_w,
    input  logic [5:0]  i_rnd,
    output logic [31:0] o_b_next
);

    logic [31:0] f;
    logic [31:0] sum;

    always_comb begin
        unique case (i_rnd[5:4])
            2'd0:    f = (i_b & i_c) | (~i_b & i_d);
            2'd1:    f = (i_b & i_d) | (i_c & ~i_d);
            2'd2:    f = i_b ^ i_c ^ i_d;
            default: f = i_c ^ (i_b | ~i_d);
        endcase
    end

    assign sum      = i_a + f + K_TABLE[i_rnd] + i_w;
    assign o_b_next = i_b + rotl32(sum, rot_amount(i_rnd));

endmodule

// File: rtl/md5_stream_hasher.sv
// md5 stream hasher top: microcoded sequencer over a 16-word block buffer
// a byte that does not complete a block leaves the sequencer idle and ready for the next byte
// a byte that completes a block runs the steps accept, load, 64 rounds and fold
// a last byte is followed by padding (0x80 head, zero fill to word 14, two length words), compression and output,
// with an extra zero fill and compression when the length spills, and output waits on any digest backpressure
// one round per cycle through a single round unit sets the block time
// reset loads the initial chaining values and clears fill, length and sequencer
module md5_stream_hasher import md5s_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word0,
    output logic [31:0] o_digest_word1,
    output logic [31:0] o_digest_word2,
    output logic [31:0] o_digest_word3
);

    t_pc         r_pc;
    t_pc         n_pc;
    t_pc         r_ret;
    t_ctrl       ctrl;
    t_flags      flags;
    logic        take_a;
    logic        take_b;

    logic [5:0]  r_fill;
    logic [63:0] r_bitlen;
    logic [23:0] r_acc;
    logic [4:0]  r_wptr;
    logic [5:0]  r_rnd;
    logic [31:0] r_chain [4];
    logic [31:0] r_rw [4];
    logic        r_out_valid;
    logic [31:0] r_digest [4];

    logic        in_acc;
    logic        out_busy;
    logic [1:0]  lane;
    logic [31:0] pad_word;
    logic [31:0] b_next;

    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic [BUF_AW-1:0] ram_raddr;
    logic [31:0]       ram_rdata;

    assign ctrl     = ucode(r_pc);
    assign in_acc   = i_in_valid & o_in_ready;
    assign out_busy = r_out_valid & ~i_out_ready;
    assign lane     = r_fill[1:0];

    assign o_in_ready     = (r_pc == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_digest_word0 = r_digest[0];
    assign o_digest_word1 = r_digest[1];
    assign o_digest_word2 = r_digest[2];
    assign o_digest_word3 = r_digest[3];

    // sequencer branch conditions
    always_comb begin
        flags.blkdone = in_acc & i_byte_valid & (r_fill == 6'd63);
        flags.lastacc = in_acc & i_last;
        flags.highpad = (r_fill[5:2] >= LEN_LO_ADDR);
        flags.wptr14  = (r_wptr == 5'd14);
        flags.wptr16  = (r_wptr == 5'd16);
        flags.rndlast = (r_rnd == 6'd63);
        flags.outbusy = out_busy;
    end

    assign take_a = eval_cond(ctrl.cond_a, flags);
    assign take_b = eval_cond(ctrl.cond_b, flags);

    always_comb begin
        priority if (take_a) begin
            n_pc = (ctrl.cond_a == C_RETURN) ? r_ret : ctrl.tgt_a;
        end else if (take_b) begin
            n_pc = ctrl.tgt_b;
        end else begin
            n_pc = ctrl.nxt;
        end
    end

    // earlier bytes of the open word, then 0x80, then zeros
    always_comb begin
        logic [31:0] acc32;
        acc32 = {8'h00, r_acc};
        for (int j = 0; j < 4; j++) begin
            if (j < int'(lane)) begin
                pad_word[8*j +: 8] = acc32[8*j +: 8];
            end else if (j == int'(lane)) begin
                pad_word[8*j +: 8] = 8'h80;
            end else begin
                pad_word[8*j +: 8] = 8'h00;
            end
        end
    end

    // buffer write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_fill[5:2];
        ram_wdata = '0;
        unique case (ctrl.op)
            OP_ACCEPT: begin
                ram_we    = in_acc & i_byte_valid & (lane == 2'd3);
                ram_wdata = {i_data_byte, r_acc};
            end
            OP_PADHEAD: begin
                ram_we    = 1'b1;
                ram_wdata = pad_word;
            end
            OP_ZLO: begin
                ram_we    = ~flags.wptr14;
                ram_waddr = r_wptr[3:0];
            end
            OP_ZHI: begin
                ram_we    = ~flags.wptr16;
                ram_waddr = r_wptr[3:0];
            end
            OP_LENLO: begin
                ram_we    = 1'b1;
                ram_waddr = LEN_LO_ADDR;
                ram_wdata = r_bitlen[31:0];
            end
            OP_LENHI: begin
                ram_we    = 1'b1;
                ram_waddr = LEN_HI_ADDR;
                ram_wdata = r_bitlen[63:32];
            end
            default: begin
            end
        endcase
    end

    // prefetch the message word of the next round
    assign ram_raddr = (ctrl.op == OP_ROUND) ? msg_index(r_rnd + 6'd1) : msg_index(r_rnd);

    md5s_ram #(
        .WIDTH (32),
        .DEPTH (BUF_WORDS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    md5s_round u_round (
        .i_a      (r_rw[0]),
        .i_b      (r_rw[1]),
        .i_c      (r_rw[2]),
        .i_d      (r_rw[3]),
        .i_w      (ram_rdata),
        .i_rnd    (r_rnd),
        .o_b_next (b_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_IDLE;
            r_ret       <= S_IDLE;
            r_fill      <= '0;
            r_bitlen    <= '0;
            r_wptr      <= '0;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < 4; j++) begin
                r_chain[j] <= IV[j];
            end
        end else begin
            r_pc <= n_pc;
            // a new digest may replace the one taken in the same cycle
            priority if (ctrl.op == OP_EMIT && !out_busy) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
            if (take_a && ctrl.set_ret) begin
                r_ret <= ctrl.ret;
            end
            unique case (ctrl.op)
                OP_ACCEPT: begin
                    if (in_acc) begin
                        // a block that fills on a last byte goes on to padding
                        r_ret <= i_last ? S_PADH : S_IDLE;
                        if (i_byte_valid) begin
                            r_fill   <= r_fill + 6'd1;
                            r_bitlen <= r_bitlen + 64'd8;
                        end
                    end
                end
                OP_PADHEAD: begin
                    r_wptr <= {1'b0, r_fill[5:2]} + 5'd1;
                end
                OP_ZLO: begin
                    if (!flags.wptr14) begin
                        r_wptr <= r_wptr + 5'd1;
                    end
                end
                OP_ZHI: begin
                    r_wptr <= flags.wptr16 ? 5'd0 : r_wptr + 5'd1;
                end
                OP_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                end
                OP_CFIN: begin
                    for (int j = 0; j < 4; j++) begin
                        r_chain[j] <= r_chain[j] + r_rw[j];
                    end
                end
                OP_EMIT: begin
                    if (!out_busy) begin
                        r_fill      <= '0;
                        r_bitlen    <= '0;
                        for (int j = 0; j < 4; j++) begin
                            r_chain[j] <= IV[j];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (ctrl.op)
            OP_ACCEPT: begin
                if (in_acc && i_byte_valid && lane != 2'd3) begin
                    r_acc[8*lane +: 8] <= i_data_byte;
                end
            end
            OP_CINIT: begin
                for (int j = 0; j < 4; j++) begin
                    r_rw[j] <= r_chain[j];
                end
            end
            OP_ROUND: begin
                r_rw[0] <= r_rw[3];
                r_rw[1] <= b_next;
                r_rw[2] <= r_rw[1];
                r_rw[3] <= r_rw[2];
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    for (int j = 0; j < 4; j++) begin
                        r_digest[j] <= r_chain[j];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_EMIT && !out_busy) |=> o_out_valid)
        else $error("digest not presented after emit step");

    a_rounds_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_CINIT) |=> (r_pc == S_CRND && r_rnd == 6'd0))
        else $error("round loop did not start at round zero");

    a_fold_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_CFIN) |-> ($past(r_pc) == S_CRND && r_rnd == 6'd0))
        else $error("fold step reached without completing 64 rounds");

    a_zero_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_ZLO) |-> (r_wptr <= 5'd14))
        else $error("zero fill ran into the length words");

endmodule
